/* hdl/lru_key_value_cache_core_assert.svh */
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent check helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// same-cycle implication
`define LRUKV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru cache check failed");

// next-cycle implication
`define LRUKV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru cache check failed");

`endif

/* hdl/lrukv_pkg.sv */
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, action codes, constants and the controller command type.
// ----------------------------------------------------------------------------
package lrukv_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load;
        logic commit;
    } lrukv_cmd_t;

endpackage

/* hdl/lrukv_ctrl.sv */
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Two-state sequencer: lookup on accept, then commit of the state update.
// ----------------------------------------------------------------------------
module lrukv_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output lrukv_pkg::lrukv_cmd_t cmd
);
    import lrukv_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_COMMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_COMMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/lrukv_dpath.sv */
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Parallel key match, recency ranks, value and key memories, result words.
// ----------------------------------------------------------------------------
module lrukv_dpath
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lrukv_pkg::lrukv_cmd_t            cmd,
    input  logic                             cfg_we,
    input  logic [lrukv_pkg::CAP_W-1:0]      cfg_wdata,
    input  logic                             action,
    input  logic signed [lrukv_pkg::DATA_W-1:0] key,
    input  logic signed [lrukv_pkg::DATA_W-1:0] value,
    output logic                             done,
    output logic                             hit,
    output logic signed [lrukv_pkg::DATA_W-1:0] read_value,
    output logic                             evicted,
    output logic signed [lrukv_pkg::DATA_W-1:0] evicted_key
);
    import lrukv_pkg::*;

    localparam int N      = MAX_ENTRIES;
    localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(N + 1);
    localparam int CMP_W  = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

    // entry state
    logic [DATA_W-1:0] key_reg  [N];
    logic [RANK_W-1:0] rank_reg [N];
    logic [RANK_W-1:0] rank_next[N];
    logic [N-1:0]      valid_reg;
    logic [N-1:0]      valid_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [CAP_W-1:0]  cap_reg;

    logic [DATA_W-1:0] val_mem [N];
    logic [DATA_W-1:0] keym_mem[N];
    logic [DATA_W-1:0] val_rdata_reg;
    logic [DATA_W-1:0] keym_rdata_reg;

    // captured item
    logic              put_reg;
    logic [DATA_W-1:0] key_in_reg;
    logic [DATA_W-1:0] value_in_reg;
    logic              hit_reg;
    logic [N-1:0]      match_reg;
    logic [RANK_W-1:0] hit_rank_reg;
    logic              evict_reg;
    logic [N-1:0]      evict_vec_reg;
    logic              ins_ok_reg;
    logic [IDX_W-1:0]  ins_idx_reg;
    logic [IDX_W-1:0]  wr_idx_reg;

    // result words
    logic              done_reg;
    logic              res_hit_reg;
    logic [DATA_W-1:0] res_value_reg;
    logic              res_evicted_reg;
    logic [DATA_W-1:0] res_evkey_reg;

    // lookup
    logic [N-1:0]      match;
    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic [CMP_W-1:0]  eff_cap;
    logic [CMP_W-1:0]  occ_inc;
    logic [OCC_W-1:0]  occ_m1;
    logic              evict_cond;
    logic [N-1:0]      lru;
    logic [N-1:0]      evict_vec;
    logic [IDX_W-1:0]  lru_idx;
    logic [N-1:0]      free_vec;
    logic [IDX_W-1:0]  ins_idx;
    logic              val_we;
    logic              ins_we;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(N))
        begin
            eff_cap = CMP_W'(N);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign occ_inc = CMP_W'(occ_reg) + CMP_W'(1);
    assign occ_m1  = occ_reg - OCC_W'(1);

    always_comb
    begin
        hit_idx  = '0;
        hit_rank = '0;
        lru_idx  = '0;
        for (int i = 0; i < N; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == key);
            lru[i]   = valid_reg[i] && (rank_reg[i] == RANK_W'(occ_m1));
            if (match[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (lru[i])
            begin
                lru_idx = lru_idx | IDX_W'(i);
            end
        end
    end

    assign hit_any    = |match;
    assign evict_cond = (action == ACT_PUT) && !hit_any && (occ_inc > eff_cap)
                        && (occ_reg != '0) && (|lru);
    assign evict_vec  = evict_cond ? lru : '0;
    assign free_vec   = ~valid_reg | evict_vec;

    always_comb
    begin
        ins_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                ins_idx = IDX_W'(i);
            end
        end
    end

    // commit
    assign ins_we = cmd.commit && put_reg && !hit_reg && ins_ok_reg;
    assign val_we = cmd.commit && put_reg && (hit_reg || ins_ok_reg);

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < N; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (cmd.commit && hit_reg)
            begin
                if (match_reg[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            else if (ins_we)
            begin
                if (IDX_W'(i) == ins_idx_reg)
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if (evict_vec_reg[i])
                begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
        if (ins_we)
        begin
            occ_next = occ_reg + OCC_W'(1) - (evict_reg ? OCC_W'(1) : OCC_W'(0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            done_reg  <= cmd.commit;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            put_reg       <= (action == ACT_PUT);
            key_in_reg    <= key;
            value_in_reg  <= value;
            hit_reg       <= hit_any;
            match_reg     <= match;
            hit_rank_reg  <= hit_rank;
            evict_reg     <= evict_cond;
            evict_vec_reg <= evict_vec;
            ins_ok_reg    <= |free_vec;
            ins_idx_reg   <= ins_idx;
            wr_idx_reg    <= hit_any ? hit_idx : ins_idx;
        end
        if (ins_we)
        begin
            key_reg[ins_idx_reg] <= key_in_reg;
        end
        if (cmd.commit)
        begin
            res_hit_reg     <= hit_reg;
            res_evicted_reg <= evict_reg;
            res_evkey_reg   <= evict_reg ? keym_rdata_reg : '0;
            if (put_reg)
            begin
                res_value_reg <= '0;
            end
            else
            begin
                res_value_reg <= hit_reg ? val_rdata_reg : MISS_VALUE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_rdata_reg <= val_mem[hit_idx];
        end
        if (val_we)
        begin
            val_mem[wr_idx_reg] <= value_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            keym_rdata_reg <= keym_mem[lru_idx];
        end
        if (ins_we)
        begin
            keym_mem[ins_idx_reg] <= key_in_reg;
        end
    end

    assign done        = done_reg;
    assign hit         = res_hit_reg;
    assign read_value  = res_value_reg;
    assign evicted     = res_evicted_reg;
    assign evicted_key = res_evkey_reg;

`include "lru_key_value_cache_core_assert.svh"

    `LRUKV_ASSERT_IMP(a_occ_bound, 1'b1, int'(occ_reg) <= N)
    `LRUKV_ASSERT_IMP(a_occ_count, 1'b1, $countones(valid_reg) == int'(occ_reg))
    `LRUKV_ASSERT_IMP(a_match_unique, cmd.load, $onehot0(match))
    `LRUKV_ASSERT_IMP(a_evict_miss, done_reg, !(res_evicted_reg && res_hit_reg))
    `LRUKV_ASSERT_NXT(a_evict_report, cmd.commit && evict_reg, done_reg && res_evicted_reg)

endmodule

/* hdl/lru_key_value_cache_core.sv */
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative get/put store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive action, key and value with start; the word is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with hit, read_value, evicted
//   and evicted_key; the receiver must take the word in that cycle, it cannot
//   stall the block.
//   Configuration: cfg_we with cfg_wdata writes the capacity register at the
//   next rising edge; write it only while no command is in flight.
//   Result path: the lookup is captured at the accepting edge and the result
//   word is registered onto the ports at the end of the commit cycle.
//   Command rate: no new command is taken until the previous one has passed
//   the lookup cycle (key match and registered memory read) and the commit
//   cycle (rank update, memory write). busy is high in the commit cycle only.
//   Reset: rst_n clears all valid bits, ranks and occupancy and sets the
//   capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             action,
    input  logic signed [lrukv_pkg::DATA_W-1:0] key,
    input  logic signed [lrukv_pkg::DATA_W-1:0] value,
    input  logic                             cfg_we,
    input  logic [lrukv_pkg::CAP_W-1:0]      cfg_wdata,
    output logic                             done,
    output logic                             hit,
    output logic signed [lrukv_pkg::DATA_W-1:0] read_value,
    output logic                             evicted,
    output logic signed [lrukv_pkg::DATA_W-1:0] evicted_key
);
    import lrukv_pkg::*;

    lrukv_cmd_t cmd;

    lrukv_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    lrukv_dpath
    #(
        .MAX_ENTRIES (MAX_ENTRIES)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .action      (action),
        .key         (key),
        .value       (value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache core testbench
// Directed tests cover empty lookups, inserts, updates and each capacity
// corner, including capacity zero, saturation above the table size and
// lowering the capacity below the current fill. Random phases then replay
// get/put traffic over small key pools at several capacities. The sender
// sends in bursts with idle gaps in all but one phase. Every result word is
// compared against an in-bench LRU predictor.
// ----------------------------------------------------------------------------
module tb_top;

    import lrukv_pkg::*;

    localparam int TABLE_DEPTH = 16;

    typedef struct {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } access_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     action;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic                     cfg_we;
    logic [CAP_W-1:0]         cfg_wdata;
    logic                     done;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;

    logic [DATA_W-1:0] cache_keys   [TABLE_DEPTH];
    logic [DATA_W-1:0] cache_values [TABLE_DEPTH];
    logic              cache_valid  [TABLE_DEPTH];
    logic [3:0]        cache_rank   [TABLE_DEPTH];
    logic [4:0]        cache_fill;
    logic [CAP_W-1:0]  capacity_reg;

    access_result_t pending_results[$];
    int             mismatch_count;

    lru_key_value_cache_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .key         (key),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void promote_entry(int slot);
        logic [3:0] old_rank;
        old_rank = cache_rank[slot];
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cache_valid[i] && cache_rank[i] < old_rank)
                cache_rank[i] = cache_rank[i] + 4'd1;
        end
        cache_rank[slot] = 4'd0;
    endfunction

    function automatic access_result_t apply_access(logic act, logic [DATA_W-1:0] k,
                                                    logic [DATA_W-1:0] v);
        access_result_t r;
        int             slot;
        int             free_slot;
        int             eff_cap;
        r.hit         = 1'b0;
        r.read_value  = '0;
        r.evicted     = 1'b0;
        r.evicted_key = '0;
        slot          = -1;
        free_slot     = -1;
        eff_cap       = (capacity_reg == 0) ? 1 :
                        (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot < 0 && cache_valid[i] && cache_keys[i] == k)
                slot = i;
        end
        if (act == ACT_GET)
        begin
            if (slot >= 0)
            begin
                r.hit        = 1'b1;
                r.read_value = cache_values[slot];
                promote_entry(slot);
            end
            else
                r.read_value = MISS_VALUE;
        end
        else if (slot >= 0)
        begin
            r.hit              = 1'b1;
            cache_values[slot] = v;
            promote_entry(slot);
        end
        else
        begin
            if (int'(cache_fill) + 1 > eff_cap && cache_fill > 0)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!r.evicted && cache_valid[i] && int'(cache_rank[i]) == cache_fill - 1)
                    begin
                        r.evicted      = 1'b1;
                        r.evicted_key  = cache_keys[i];
                        cache_valid[i] = 1'b0;
                        cache_rank[i]  = 4'd0;
                        cache_fill     = cache_fill - 5'd1;
                    end
                end
            end
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (free_slot < 0 && !cache_valid[i])
                    free_slot = i;
            end
            if (free_slot >= 0)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (cache_valid[i])
                        cache_rank[i] = cache_rank[i] + 4'd1;
                end
                cache_valid[free_slot]  = 1'b1;
                cache_keys[free_slot]   = k;
                cache_values[free_slot] = v;
                cache_rank[free_slot]   = 4'd0;
                cache_fill              = cache_fill + 5'd1;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        access_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no access outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, hit);
                    mismatch_count++;
                end
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, actual %h", want.read_value, read_value);
                    mismatch_count++;
                end
                if (evicted !== want.evicted)
                begin
                    $error("evicted: expected %0d, actual %0d", want.evicted, evicted);
                    mismatch_count++;
                end
                if (evicted_key !== want.evicted_key)
                begin
                    $error("evicted_key: expected %h, actual %h", want.evicted_key, evicted_key);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_access(input logic act, input logic [DATA_W-1:0] k,
                               input logic [DATA_W-1:0] v);
        @(negedge clk);
        start  <= 1'b1;
        action <= act;
        key    <= k;
        value  <= v;
        do @(posedge clk); while (busy);
        pending_results.push_back(apply_access(act, k, v));
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain_results();
        pause_sender(0);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        capacity_reg = cap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_empty_lookup();
        send_access(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_access(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_put_and_update();
        send_access(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_access(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_access(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_access(ACT_GET, 32'h8000_0000, 32'h1234_5678);
        send_access(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_access(ACT_PUT, 32'h8000_0000, 32'h0000_0000);
        send_access(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_access(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_access(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_capacity_shrink();
        write_capacity(5'd1);
        send_access(ACT_PUT, 32'd5, 32'd55);
        send_access(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_access(ACT_PUT, 32'h0000_0000, 32'd1);
        send_access(ACT_PUT, 32'd6, 32'd66);
    endtask

    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_access(ACT_PUT, 32'd7, 32'd77);
        send_access(ACT_PUT, 32'd8, 32'd88);
    endtask

    task automatic test_capacity_saturation();
        write_capacity(5'd31);
        send_access(ACT_PUT, 32'd9, 32'd99);
        send_access(ACT_PUT, 32'd10, 32'd100);
    endtask

    task automatic test_lru_order();
        write_capacity(5'd5);
        send_access(ACT_PUT, 32'd11, 32'd111);
        send_access(ACT_GET, 32'd9, 32'd0);
        send_access(ACT_PUT, 32'd12, 32'd122);
        send_access(ACT_PUT, 32'd13, 32'd133);
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0]  phase_caps[10];
        logic [DATA_W-1:0] key_pool[$];
        logic [DATA_W-1:0] pick_key;
        int                pool_size;
        int                burst_left;
        logic              bursty;
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd3, 5'd8, 5'd12, 5'd16};
        for (int p = 0; p < 10; p++)
        begin
            write_capacity(phase_caps[p]);
            key_pool.delete();
            pool_size = (p == 3) ? 24 : $urandom_range(1, 20);
            for (int i = 0; i < pool_size; i++)
                key_pool.push_back($urandom);
            bursty     = (p != 4);
            burst_left = $urandom_range(1, 12);
            for (int n = 0; n < 85; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pick_key = $urandom;
                else
                    pick_key = key_pool[$urandom_range(0, pool_size - 1)];
                send_access(1'($urandom_range(0, 1)), pick_key, $urandom);
                if (bursty)
                begin
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            drain_results();
                        else if ($urandom_range(0, 5) == 0)
                            pause_sender($urandom_range(10, 24));
                        else
                            pause_sender($urandom_range(0, 6));
                        burst_left = $urandom_range(1, 12);
                    end
                end
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        action         = ACT_GET;
        key            = '0;
        value          = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        mismatch_count = 0;
        capacity_reg   = CAP_RESET;
        cache_fill     = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            cache_keys[i]   = '0;
            cache_values[i] = '0;
            cache_valid[i]  = 1'b0;
            cache_rank[i]   = 4'd0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_lookup();
        test_put_and_update();
        test_capacity_shrink();
        test_capacity_zero();
        test_capacity_saturation();
        test_lru_order();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
